>>> sv/kmj_pkg.sv
`default_nettype none
package kmj_pkg;

  localparam int unsigned NUM_ROWS    = 8;
  localparam int unsigned JOY_ROW     = 8;
  localparam int unsigned NUM_BUTTONS = 8;
  localparam int unsigned KEY_COUNT   = 52;
  localparam int unsigned CAPS_KEY    = 23;
  localparam int unsigned SYMBOL_KEY  = 33;
  localparam int unsigned IDX_W       = 6;
  localparam int unsigned MAP_W       = NUM_BUTTONS * IDX_W;
  localparam logic [7:0]  READ_BASE   = 8'hBF;

  // operation codes
  localparam logic [1:0] OP_KEY_EVENT = 2'd0;
  localparam logic [1:0] OP_JOY_POLL  = 2'd1;
  localparam logic [1:0] OP_PORT_READ = 2'd2;

  // configuration register indexes
  localparam logic REG_JOY_KEY_MAP = 1'b0;
  localparam logic REG_JOY_ENABLE  = 1'b1;

  typedef logic [7:0] row_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [6:0] key_index;
    logic       key_release;
    logic [7:0] joy_buttons;
    logic [7:0] port_high;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] joystick_byte;
  } result_t;

  typedef struct packed {
    logic             index;
    logic [MAP_W-1:0] value;
  } cfg_t;

  typedef struct packed {
    logic [MAP_W-1:0] key_map;
    logic             enable;
  } joy_cfg_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] row;
    logic [4:0] mask;
    logic [2:0] exrow;
    logic [4:0] exmask;
  } key_entry_t;

  // release_mask drives bits high first, press_mask then drives them low
  // (joystick row takes the opposite level)
  typedef struct packed {
    row_t [JOY_ROW:0] release_mask;
    row_t [JOY_ROW:0] press_mask;
  } joy_masks_t;

  function automatic key_entry_t key_entry(input logic [IDX_W-1:0] idx);
    key_entry_t e;
    e = '0;
    case (idx)
      6'd0:  e = '{1'b1, 4'd0, 5'h00, 3'd0, 5'h00};
      6'd1:  e = '{1'b1, 4'd3, 5'h01, 3'd0, 5'h00};
      6'd2:  e = '{1'b1, 4'd3, 5'h02, 3'd0, 5'h00};
      6'd3:  e = '{1'b1, 4'd3, 5'h04, 3'd0, 5'h00};
      6'd4:  e = '{1'b1, 4'd3, 5'h08, 3'd0, 5'h00};
      6'd5:  e = '{1'b1, 4'd3, 5'h10, 3'd0, 5'h00};
      6'd6:  e = '{1'b1, 4'd4, 5'h10, 3'd0, 5'h00};
      6'd7:  e = '{1'b1, 4'd4, 5'h08, 3'd0, 5'h00};
      6'd8:  e = '{1'b1, 4'd4, 5'h04, 3'd0, 5'h00};
      6'd9:  e = '{1'b1, 4'd4, 5'h02, 3'd0, 5'h00};
      6'd10: e = '{1'b1, 4'd4, 5'h01, 3'd0, 5'h00};
      6'd11: e = '{1'b1, 4'd4, 5'h01, 3'd0, 5'h01};
      6'd12: e = '{1'b1, 4'd2, 5'h01, 3'd0, 5'h00};
      6'd13: e = '{1'b1, 4'd2, 5'h02, 3'd0, 5'h00};
      6'd14: e = '{1'b1, 4'd2, 5'h04, 3'd0, 5'h00};
      6'd15: e = '{1'b1, 4'd2, 5'h08, 3'd0, 5'h00};
      6'd16: e = '{1'b1, 4'd2, 5'h10, 3'd0, 5'h00};
      6'd17: e = '{1'b1, 4'd5, 5'h10, 3'd0, 5'h00};
      6'd18: e = '{1'b1, 4'd5, 5'h08, 3'd0, 5'h00};
      6'd19: e = '{1'b1, 4'd5, 5'h04, 3'd0, 5'h00};
      6'd20: e = '{1'b1, 4'd5, 5'h02, 3'd0, 5'h00};
      6'd21: e = '{1'b1, 4'd5, 5'h01, 3'd0, 5'h00};
      6'd22: e = '{1'b1, 4'd6, 5'h01, 3'd0, 5'h00};
      6'd23: e = '{1'b1, 4'd0, 5'h01, 3'd0, 5'h00};
      6'd24: e = '{1'b1, 4'd1, 5'h01, 3'd0, 5'h00};
      6'd25: e = '{1'b1, 4'd1, 5'h02, 3'd0, 5'h00};
      6'd26: e = '{1'b1, 4'd1, 5'h04, 3'd0, 5'h00};
      6'd27: e = '{1'b1, 4'd1, 5'h08, 3'd0, 5'h00};
      6'd28: e = '{1'b1, 4'd1, 5'h10, 3'd0, 5'h00};
      6'd29: e = '{1'b1, 4'd6, 5'h10, 3'd0, 5'h00};
      6'd30: e = '{1'b1, 4'd6, 5'h08, 3'd0, 5'h00};
      6'd31: e = '{1'b1, 4'd6, 5'h04, 3'd0, 5'h00};
      6'd32: e = '{1'b1, 4'd6, 5'h02, 3'd0, 5'h00};
      6'd33: e = '{1'b1, 4'd7, 5'h02, 3'd0, 5'h00};
      6'd34: e = '{1'b1, 4'd0, 5'h01, 3'd7, 5'h02};
      6'd35: e = '{1'b1, 4'd0, 5'h02, 3'd0, 5'h00};
      6'd36: e = '{1'b1, 4'd0, 5'h04, 3'd0, 5'h00};
      6'd37: e = '{1'b1, 4'd0, 5'h08, 3'd0, 5'h00};
      6'd38: e = '{1'b1, 4'd7, 5'h01, 3'd0, 5'h00};
      6'd39: e = '{1'b1, 4'd0, 5'h10, 3'd0, 5'h00};
      6'd40: e = '{1'b1, 4'd7, 5'h10, 3'd0, 5'h00};
      6'd41: e = '{1'b1, 4'd7, 5'h08, 3'd0, 5'h00};
      6'd42: e = '{1'b1, 4'd7, 5'h04, 3'd0, 5'h00};
      6'd43: e = '{1'b1, 4'd4, 5'h08, 3'd0, 5'h01};
      6'd44: e = '{1'b1, 4'd4, 5'h10, 3'd0, 5'h01};
      6'd45: e = '{1'b1, 4'd3, 5'h10, 3'd0, 5'h01};
      6'd46: e = '{1'b1, 4'd4, 5'h04, 3'd0, 5'h01};
      6'd47: e = '{1'b1, 4'd8, 5'h02, 3'd0, 5'h00};
      6'd48: e = '{1'b1, 4'd8, 5'h01, 3'd0, 5'h00};
      6'd49: e = '{1'b1, 4'd8, 5'h08, 3'd0, 5'h00};
      6'd50: e = '{1'b1, 4'd8, 5'h04, 3'd0, 5'h00};
      6'd51: e = '{1'b1, 4'd8, 5'h10, 3'd0, 5'h00};
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage
`default_nettype wire

>>> sv/kmj_item_if.sv
`default_nettype none
interface kmj_item_if;
  import kmj_pkg::*;
  logic  valid;
  logic  ready;
  item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

>>> sv/kmj_result_if.sv
`default_nettype none
interface kmj_result_if;
  import kmj_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

>>> sv/kmj_cfg_if.sv
`default_nettype none
interface kmj_cfg_if;
  import kmj_pkg::*;
  logic valid;
  logic ready;
  cfg_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

>>> sv/kmj_cfg_regs.sv
`default_nettype none
module kmj_cfg_regs (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr_en,
  input  wire kmj_pkg::cfg_t     wr,
  output kmj_pkg::joy_cfg_t      joy_cfg
);
  import kmj_pkg::*;

  joy_cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (wr_en) begin
      case (wr.index)
        REG_JOY_KEY_MAP: regs.key_map <= wr.value;
        REG_JOY_ENABLE:  regs.enable  <= wr.value[0];
        default: ;
      endcase
    end
  end

  assign joy_cfg = regs;

endmodule
`default_nettype wire

>>> sv/kmj_joy_map.sv
`default_nettype none
module kmj_joy_map (
  input  wire logic [kmj_pkg::MAP_W-1:0] key_map,
  input  wire logic [7:0]                buttons,
  output kmj_pkg::joy_masks_t            masks
);
  import kmj_pkg::*;

  key_entry_t e;
  row_t       m;

  // each button drives its mapped key: low buttons release, high buttons press
  always_comb begin
    masks = '0;
    e     = '0;
    m     = '0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      e = key_entry(key_map[i*IDX_W +: IDX_W]);
      for (int r = 0; r <= JOY_ROW; r++) begin
        m = '0;
        if (e.valid) begin
          if (e.row == 4'(r)) begin
            m = m | {3'b000, e.mask};
          end
          if ((r < NUM_ROWS) && (e.exmask != 5'h00) && (e.exrow == 3'(r))) begin
            m = m | {3'b000, e.exmask};
          end
        end
        if (buttons[i]) begin
          masks.press_mask[r] = masks.press_mask[r] | m;
        end else begin
          masks.release_mask[r] = masks.release_mask[r] | m;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/kmj_matrix.sv
`default_nettype none
module kmj_matrix (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               apply,
  input  wire kmj_pkg::item_t     item,
  input  wire kmj_pkg::joy_cfg_t  joy_cfg,
  output kmj_pkg::result_t        res
);
  import kmj_pkg::*;

  row_t [NUM_ROWS-1:0] key_rows;
  row_t [NUM_ROWS-1:0] key_rows_next;
  row_t                joystick_row;
  row_t                joystick_row_next;
  logic [7:0]          last_buttons;
  logic [7:0]          last_buttons_next;
  logic                caps_lock;
  logic                caps_lock_next;
  logic                symbol_lock;
  logic                symbol_lock_next;

  joy_masks_t          jm;
  key_entry_t          e;
  logic                key_ok;
  logic                press;
  logic                is_caps;
  logic                is_sym;
  logic [2:0]          exrow;
  logic [4:0]          exmask;
  row_t [JOY_ROW:0]    km;
  row_t [NUM_ROWS-1:0] base;
  row_t                rd;

  kmj_joy_map u_joy_map (
    .key_map (joy_cfg.key_map),
    .buttons (item.joy_buttons),
    .masks   (jm)
  );

  always_comb begin
    key_rows_next     = key_rows;
    joystick_row_next = joystick_row;
    last_buttons_next = last_buttons;
    caps_lock_next    = caps_lock;
    symbol_lock_next  = symbol_lock;

    key_ok  = item.key_index < 7'(KEY_COUNT);
    e       = key_entry(item.key_index[IDX_W-1:0]);
    press   = !item.key_release;
    is_caps = press && (item.key_index == 7'(CAPS_KEY));
    is_sym  = press && (item.key_index == 7'(SYMBOL_KEY));

    // sticky locks add a shift to keys without a shift of their own
    exrow  = e.exrow;
    exmask = e.exmask;
    if (exmask == 5'h00) begin
      if (caps_lock) begin
        exrow  = 3'd0;
        exmask = 5'h01;
      end else if (symbol_lock) begin
        exrow  = 3'd7;
        exmask = 5'h02;
      end
    end
    if (is_caps || is_sym) begin
      exmask = 5'h00;
    end

    for (int r = 0; r <= JOY_ROW; r++) begin
      km[r] = '0;
      if (e.row == 4'(r)) begin
        km[r] = km[r] | {3'b000, e.mask};
      end
      if ((r < NUM_ROWS) && (exrow == 3'(r))) begin
        km[r] = km[r] | {3'b000, exmask};
      end
    end

    // a lock key press releases the other shift row first
    base = key_rows;
    if (is_caps) begin
      base[7] = 8'hFF;
    end
    if (is_sym) begin
      base[0] = 8'hFF;
    end

    rd = READ_BASE;
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (!item.port_high[r]) begin
        rd = rd & key_rows[r];
      end
    end

    res.read_data = '0;

    case (item.operation)
      OP_KEY_EVENT: begin
        if (key_ok) begin
          if (press) begin
            if (is_caps) begin
              symbol_lock_next = 1'b0;
              caps_lock_next   = !caps_lock;
            end
            if (is_sym) begin
              caps_lock_next   = 1'b0;
              symbol_lock_next = !symbol_lock;
            end
            for (int r = 0; r < NUM_ROWS; r++) begin
              key_rows_next[r] = base[r] & ~km[r];
            end
            joystick_row_next = joystick_row & ~km[JOY_ROW];
          end else begin
            for (int r = 0; r < NUM_ROWS; r++) begin
              key_rows_next[r] = key_rows[r] | km[r];
            end
            joystick_row_next = joystick_row | km[JOY_ROW];
          end
        end
      end
      OP_JOY_POLL: begin
        if (joy_cfg.enable && (item.joy_buttons != last_buttons)) begin
          last_buttons_next = item.joy_buttons;
          for (int r = 0; r < NUM_ROWS; r++) begin
            key_rows_next[r] = (key_rows[r] | jm.release_mask[r]) & ~jm.press_mask[r];
          end
          joystick_row_next = (joystick_row & ~jm.release_mask[JOY_ROW])
                              | jm.press_mask[JOY_ROW];
        end
      end
      OP_PORT_READ: begin
        res.read_data = rd;
      end
      default: ;
    endcase

    res.joystick_byte = joystick_row_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_rows     <= '1;
      joystick_row <= '0;
      last_buttons <= '0;
      caps_lock    <= 1'b0;
      symbol_lock  <= 1'b0;
    end else if (apply) begin
      key_rows     <= key_rows_next;
      joystick_row <= joystick_row_next;
      last_buttons <= last_buttons_next;
      caps_lock    <= caps_lock_next;
      symbol_lock  <= symbol_lock_next;
    end
  end

endmodule
`default_nettype wire

>>> sv/keyboard_matrix_with_joystick_map_top.sv
// Eight-row keyboard matrix with an active-high joystick byte. Each accepted
// item (key event, joystick poll or port read) gives exactly one result
// carrying the read data and the joystick byte after the item. Items are
// taken one per clock cycle unless results stall; a result passes the
// input register, then the matrix update and the result register. The state
// update is registered together with the result, and the next item sees it
// at once. The output register lets a new item be taken while a result waits
// to be transferred. Configuration writes are always taken and must be done
// while no item is in flight.
`default_nettype none
module keyboard_matrix_with_joystick_map_top (
  input  wire logic    clk,
  input  wire logic    rst,
  kmj_item_if.sink     item,
  kmj_result_if.source result,
  kmj_cfg_if.sink      cfg
);
  import kmj_pkg::*;

  logic     s1_valid;
  item_t    s1_item;
  logic     out_valid;
  result_t  out_data;
  logic     out_free;
  logic     s1_adv;
  joy_cfg_t joy_cfg;
  result_t  res;

  assign out_free   = !out_valid || result.ready;
  assign s1_adv     = s1_valid && out_free;
  assign item.ready = !s1_valid || out_free;
  assign cfg.ready  = 1'b1;

  kmj_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cfg.valid),
    .wr      (cfg.data),
    .joy_cfg (joy_cfg)
  );

  kmj_matrix u_matrix (
    .clk     (clk),
    .rst     (rst),
    .apply   (s1_adv),
    .item    (s1_item),
    .joy_cfg (joy_cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (item.ready) begin
        s1_valid <= item.valid;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_item <= item.data;
    end
    if (s1_adv) begin
      out_data <= res;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

endmodule
`default_nettype wire

>>> sim/kmj_matrix_check.sv
module kmj_matrix_check
  import kmj_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  kmj_item_if   item,
  kmj_result_if result,
  kmj_cfg_if    cfg,
  output int    failures,
  output int    pending
);

  // row (4b), mask (8b), extra row (4b), extra mask (8b)
  typedef struct packed {
    logic [3:0] row;
    logic [7:0] mask;
    logic [3:0] exrow;
    logic [7:0] exmask;
  } matrix_key_t;

  localparam logic [23:0] KEY_TABLE [KEY_COUNT] = '{
    24'h0_00_0_00,
    24'h3_01_0_00, 24'h3_02_0_00, 24'h3_04_0_00, 24'h3_08_0_00, 24'h3_10_0_00,
    24'h4_10_0_00, 24'h4_08_0_00, 24'h4_04_0_00, 24'h4_02_0_00, 24'h4_01_0_00,
    24'h4_01_0_01,
    24'h2_01_0_00, 24'h2_02_0_00, 24'h2_04_0_00, 24'h2_08_0_00, 24'h2_10_0_00,
    24'h5_10_0_00, 24'h5_08_0_00, 24'h5_04_0_00, 24'h5_02_0_00, 24'h5_01_0_00,
    24'h6_01_0_00,
    24'h0_01_0_00,
    24'h1_01_0_00, 24'h1_02_0_00, 24'h1_04_0_00, 24'h1_08_0_00, 24'h1_10_0_00,
    24'h6_10_0_00, 24'h6_08_0_00, 24'h6_04_0_00, 24'h6_02_0_00,
    24'h7_02_0_00, 24'h0_01_7_02,
    24'h0_02_0_00, 24'h0_04_0_00, 24'h0_08_0_00, 24'h7_01_0_00, 24'h0_10_0_00,
    24'h7_10_0_00, 24'h7_08_0_00, 24'h7_04_0_00,
    24'h4_08_0_01, 24'h4_10_0_01, 24'h3_10_0_01, 24'h4_04_0_01,
    24'h8_02_0_00, 24'h8_01_0_00, 24'h8_08_0_00, 24'h8_04_0_00, 24'h8_10_0_00
  };

  // rows 0..7 are the matrix, the last slot is the joystick byte
  row_t             rows [JOY_ROW+1];
  logic [MAP_W-1:0] joy_map;
  logic             joy_on;
  logic [7:0]       last_buttons;
  logic             caps_on;
  logic             symbol_on;
  result_t          want_results [$];
  int               mismatches;
  int               result_num;

  assign failures = mismatches;

  task automatic report(input string msg);
    $display("mismatch at result %0d: %s", result_num, msg);
    mismatches++;
  endtask

  task automatic drive_level(input int r, input row_t m, input bit high);
    if (high) begin
      rows[r] = rows[r] | m;
    end else begin
      rows[r] = rows[r] & ~m;
    end
  endtask

  task automatic key_event(input logic [6:0] key, input bit up);
    matrix_key_t e;
    int          xr;
    row_t        xm;
    if (key >= KEY_COUNT) return;
    e  = KEY_TABLE[key];
    xr = e.exrow;
    xm = e.exmask;
    // sticky shift only on keys without their own extra bit
    if (xm == '0) begin
      if (caps_on) begin
        xm = 8'h01;
        xr = 0;
      end else if (symbol_on) begin
        xm = 8'h02;
        xr = 7;
      end
    end
    if (!up) begin
      if (key == CAPS_KEY) begin
        symbol_on = 1'b0;
        rows[7]   = 8'hFF;
        xm        = '0;
        caps_on   = !caps_on;
      end
      if (key == SYMBOL_KEY) begin
        caps_on   = 1'b0;
        rows[0]   = 8'hFF;
        xm        = '0;
        symbol_on = !symbol_on;
      end
    end
    drive_level(e.row, e.mask, up);
    drive_level(xr, xm, up);
  endtask

  task automatic button_level(input int b, input bit high);
    logic [IDX_W-1:0] k;
    matrix_key_t      e;
    k = joy_map[IDX_W*b +: IDX_W];
    if (k >= KEY_COUNT) return;
    e = KEY_TABLE[k];
    if (e.exmask != '0) drive_level(e.exrow, e.exmask, high);
    // joystick byte is active high, matrix active low
    drive_level(e.row, e.mask, (e.row == JOY_ROW) ? !high : high);
  endtask

  task automatic joy_poll(input logic [7:0] buttons);
    if (!joy_on || buttons == last_buttons) return;
    last_buttons = buttons;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (!buttons[i]) button_level(i, 1'b1);
    end
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (buttons[i]) button_level(i, 1'b0);
    end
  endtask

  function automatic row_t port_value(input logic [7:0] port);
    row_t acc;
    acc = READ_BASE;
    for (int i = 0; i < NUM_ROWS; i++) begin
      if (!port[i]) acc = acc & rows[i];
    end
    return acc;
  endfunction

  always @(posedge clk) begin : watch
    item_t   it;
    result_t got;
    result_t want;
    if (rst) begin
      for (int i = 0; i <= JOY_ROW; i++) rows[i] = (i == JOY_ROW) ? 8'h00 : 8'hFF;
      joy_map      = '0;
      joy_on       = 1'b0;
      last_buttons = '0;
      caps_on      = 1'b0;
      symbol_on    = 1'b0;
      want_results.delete();
    end else begin
      if (result.valid && result.ready) begin
        got = result.data;
        if (want_results.size() == 0) begin
          report($sformatf("unexpected result %02h/%02h", got.read_data, got.joystick_byte));
        end else begin
          want = want_results.pop_front();
          if (got.read_data !== want.read_data)
            report($sformatf("read_data %02h, expected %02h", got.read_data, want.read_data));
          if (got.joystick_byte !== want.joystick_byte)
            report($sformatf("joystick_byte %02h, expected %02h",
                             got.joystick_byte, want.joystick_byte));
        end
        result_num++;
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.data.index)
          REG_JOY_KEY_MAP: joy_map = cfg.data.value;
          REG_JOY_ENABLE:  joy_on  = cfg.data.value[0];
          default: ;
        endcase
      end
      if (item.valid && item.ready) begin
        it             = item.data;
        want.read_data = '0;
        case (it.operation)
          OP_KEY_EVENT: key_event(it.key_index, it.key_release);
          OP_JOY_POLL:  joy_poll(it.joy_buttons);
          OP_PORT_READ: want.read_data = port_value(it.port_high);
          default: ;
        endcase
        want.joystick_byte = rows[JOY_ROW];
        want_results.push_back(want);
      end
    end
    pending <= want_results.size();
  end

endmodule

>>> sim/tb_keyboard_matrix_with_joystick_map_top.sv
module tb_keyboard_matrix_with_joystick_map_top;
  import kmj_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int         LIMIT     = 200000;

  logic clk = 1'b0;
  logic rst;
  bit   gaps_on;
  int   failures;
  int   pending;
  int   cycles;
  logic [7:0] prev_buttons;

  kmj_item_if   item_bus ();
  kmj_result_if result_bus ();
  kmj_cfg_if    cfg_bus ();

  keyboard_matrix_with_joystick_map_top dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_bus),
    .result (result_bus),
    .cfg    (cfg_bus)
  );

  kmj_matrix_check matrix_check (
    .clk      (clk),
    .rst      (rst),
    .item     (item_bus),
    .result   (result_bus),
    .cfg      (cfg_bus),
    .failures (failures),
    .pending  (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[keyboard_matrix_with_joystick_map_top] ERROR");
      $finish;
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    result_bus.ready <= !gaps_on || ($urandom_range(99) >= 28);
  end

  // each idle cycle is drawn on its own, with a chance of 28 in 100 while gaps are on
  task automatic send_item(input item_t it);
    while (gaps_on && $urandom_range(99) < 28) begin
      item_bus.valid <= 1'b0;
      @(posedge clk);
    end
    item_bus.valid <= 1'b1;
    item_bus.data  <= it;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
  endtask

  // wait for every outstanding result, then let the pipeline empty
  task automatic settle();
    item_bus.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [MAP_W-1:0] key_map, input logic enable);
    cfg_t w;
    for (int r = 0; r < 2; r++) begin
      w.index = (r == 0) ? REG_JOY_KEY_MAP : REG_JOY_ENABLE;
      w.value = (r == 0) ? key_map : MAP_W'(enable);
      cfg_bus.valid <= 1'b1;
      cfg_bus.data  <= w;
      @(posedge clk);
      while (!cfg_bus.ready) @(posedge clk);
    end
    cfg_bus.valid <= 1'b0;
  endtask

  function automatic item_t noise_item();
    item_t it;
    it.operation   = 2'($urandom_range(3));
    it.key_index   = 7'($urandom_range(127));
    it.key_release = 1'($urandom_range(1));
    it.joy_buttons = 8'($urandom_range(255));
    it.port_high   = 8'($urandom_range(255));
    return it;
  endfunction

  task automatic key_action(input int key, input bit up);
    item_t it;
    it             = noise_item();
    it.operation   = OP_KEY_EVENT;
    it.key_index   = 7'(key);
    it.key_release = up;
    send_item(it);
  endtask

  task automatic read_rows(input logic [7:0] port);
    item_t it;
    it           = noise_item();
    it.operation = OP_PORT_READ;
    it.port_high = port;
    send_item(it);
  endtask

  task automatic poll_buttons(input logic [7:0] buttons);
    item_t it;
    it             = noise_item();
    it.operation   = OP_JOY_POLL;
    it.joy_buttons = buttons;
    send_item(it);
  endtask

  // mostly valid key indices, now and then one beyond the end of the table
  function automatic logic [MAP_W-1:0] random_map();
    logic [MAP_W-1:0] m;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      m[IDX_W*i +: IDX_W] = ($urandom_range(9) == 0) ? IDX_W'($urandom_range(KEY_COUNT, 63))
                                                      : IDX_W'($urandom_range(KEY_COUNT - 1));
    end
    return m;
  endfunction

  task automatic run_phase(input int count, input bit calm, input int pause_at);
    item_t it;
    int    pick;
    gaps_on = !calm;
    for (int n = 0; n < count; n++) begin
      if (n == pause_at) settle();
      it   = noise_item();
      pick = $urandom_range(99);
      if (pick < 45)      it.operation = OP_KEY_EVENT;
      else if (pick < 70) it.operation = OP_JOY_POLL;
      else if (pick < 95) it.operation = OP_PORT_READ;
      else                it.operation = OP_UNUSED;
      pick = $urandom_range(99);
      if (pick < 10)      it.key_index = ($urandom_range(1) != 0) ? 7'(CAPS_KEY) : 7'(SYMBOL_KEY);
      else if (pick < 85) it.key_index = 7'($urandom_range(KEY_COUNT - 1));
      if ($urandom_range(4) == 0) it.joy_buttons = prev_buttons;
      if ($urandom_range(9) < 3)  it.port_high = ~(8'h01 << $urandom_range(7));
      if (it.operation == OP_JOY_POLL) prev_buttons = it.joy_buttons;
      send_item(it);
    end
  endtask

  initial begin
    rst               = 1'b1;
    cycles            = 0;
    gaps_on           = 1'b1;
    prev_buttons      = '0;
    item_bus.valid    = 1'b0;
    item_bus.data     = '0;
    result_bus.ready  = 1'b0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.data      = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // matrix keys, sticky locks and ignored indices under the reset settings
    read_rows(8'h00);
    read_rows(8'hFF);
    key_action(1, 1'b0);
    read_rows(8'hF7);
    key_action(1, 1'b1);
    key_action(CAPS_KEY, 1'b0);
    key_action(5, 1'b0);
    read_rows(8'h00);
    key_action(5, 1'b1);
    key_action(CAPS_KEY, 1'b0);
    key_action(CAPS_KEY, 1'b1);
    key_action(SYMBOL_KEY, 1'b0);
    key_action(12, 1'b0);
    read_rows(8'h00);
    key_action(12, 1'b1);
    key_action(SYMBOL_KEY, 1'b0);
    key_action(34, 1'b0);
    key_action(11, 1'b0);
    read_rows(8'h00);
    key_action(47, 1'b1);
    key_action(0, 1'b0);
    key_action(KEY_COUNT, 1'b0);
    key_action(127, 1'b0);
    poll_buttons(8'hFF);
    send_item('{OP_UNUSED, 7'h7F, 1'b1, 8'hFF, 8'h00});

    // joystick buttons onto the joystick row, an extra-bit key, caps key and a dead entry
    settle();
    set_config({6'd63, 6'd23, 6'd34, 6'd51, 6'd50, 6'd49, 6'd48, 6'd47}, 1'b1);
    poll_buttons(8'h00);
    poll_buttons(8'hFF);
    poll_buttons(8'hFF);
    poll_buttons(8'h0F);
    poll_buttons(8'hF0);
    read_rows(8'h00);
    settle();
    set_config('1, 1'b1);
    poll_buttons(8'hA5);
    settle();
    set_config('0, 1'b1);
    poll_buttons(8'h5A);
    prev_buttons = 8'h5A;

    settle();
    set_config(random_map(), 1'b1);
    run_phase(100, 1'b0, -1);
    settle();
    set_config(random_map(), 1'b0);
    run_phase(60, 1'b0, -1);
    settle();
    set_config('1, 1'b1);
    run_phase(30, 1'b0, -1);
    settle();
    set_config(random_map(), 1'b1);
    run_phase(120, 1'b1, -1);
    settle();
    set_config(random_map(), 1'b1);
    run_phase(90, 1'b0, 45);
    settle();

    if (failures == 0 && pending == 0) begin
      $display("[keyboard_matrix_with_joystick_map_top] OK");
    end else begin
      $display("[keyboard_matrix_with_joystick_map_top] ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/kmj_pkg.sv
sv/kmj_item_if.sv
sv/kmj_result_if.sv
sv/kmj_cfg_if.sv
sv/kmj_cfg_regs.sv
sv/kmj_joy_map.sv
sv/kmj_matrix.sv
sv/keyboard_matrix_with_joystick_map_top.sv
sim/kmj_matrix_check.sv
sim/tb_keyboard_matrix_with_joystick_map_top.sv
